FILE: rtl/toeq_pkg.sv
`timescale 1ns / 1ps

package toeq_pkg;

    // Default sizes of the store.
    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 32;

    // Widths of the request and result fields as they travel on the ports.
    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int TYPE_W   = 8;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

    // Controller states.
    typedef enum logic [0:0] {
        CTL_IDLE,
        CTL_COMMIT
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: rtl/toeq_ctrl.sv
`timescale 1ns / 1ps

module toeq_ctrl
    import toeq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t dp_stat,
    output ctl_cmd_t ctl_cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A request is captured in idle, and committed
    // from the commit state once the result register is free.
    always_comb begin
        state_next      = state_reg;
        req_ready       = 1'b0;
        ctl_cmd.capture = 1'b0;
        ctl_cmd.commit  = 1'b0;
        case (state_reg)
            CTL_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    ctl_cmd.capture = 1'b1;
                    state_next      = CTL_COMMIT;
                end
            end
            CTL_COMMIT: begin
                if (!dp_stat.out_busy) begin
                    ctl_cmd.commit = 1'b1;
                    state_next     = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/toeq_datapath.sv
`timescale 1ns / 1ps

module toeq_datapath
    import toeq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctl_cmd_t            ctl_cmd,
    output dp_stat_t            dp_stat,
    input  logic [OP_W-1:0]     in_op,
    input  logic [TIME_W-1:0]   in_time,
    input  logic [TYPE_W-1:0]   in_type,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [TIME_W-1:0]   out_time,
    output logic [TYPE_W-1:0]   out_type,
    output logic [TAG_W-1:0]    out_tag,
    output logic [COUNT_W-1:0]  out_count,
    output logic                out_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LVL   = $clog2(DEPTH);

    // Sorted store, entry 0 is the head. Entries at and above the count are don't-care.
    logic [TIME_BITS-1:0] slot_time_reg [DEPTH];
    logic [TYPE_W-1:0]    slot_type_reg [DEPTH];
    logic [TAG_W-1:0]     slot_tag_reg  [DEPTH];
    logic [TIME_BITS-1:0] slot_time_next [DEPTH];
    logic [TYPE_W-1:0]    slot_type_next [DEPTH];
    logic [TAG_W-1:0]     slot_tag_next  [DEPTH];
    logic [CNT_W-1:0]     occ_reg;
    logic [CNT_W-1:0]     occ_next;

    // Captured request and its per-entry compare results.
    logic [OP_W-1:0]      op_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [TYPE_W-1:0]    type_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [DEPTH-1:0]     after_reg;
    logic [DEPTH-1:0]     after_next;
    logic [DEPTH-1:0]     match_reg;
    logic [DEPTH-1:0]     match_next;

    // Result register.
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [TIME_W-1:0]    out_time_reg;
    logic [TYPE_W-1:0]    out_type_reg;
    logic [TAG_W-1:0]     out_tag_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic                 out_empty_reg;

    logic [TIME_BITS+TIME_W-1:0] in_time_ext;
    logic [TIME_BITS-1:0]        in_time_fit;
    logic [TIME_BITS+TIME_W-1:0] head_time_ext;
    logic [CNT_W+COUNT_W-1:0]    count_ext;
    logic [DEPTH-1:0]            pre [LVL+1];
    logic                        found;
    logic                        full;
    logic [STATUS_W-1:0]         status_next;
    logic                        do_insert;
    logic                        do_remove;

    // The incoming time is held to the stored width.
    assign in_time_ext = {{TIME_BITS{1'b0}}, in_time};
    assign in_time_fit = in_time_ext[TIME_BITS-1:0];

    // Each entry compares itself against the incoming request. Since the store is
    // sorted, the set of entries that lie after the new event forms a contiguous tail.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            after_next[i] = (CNT_W'(i) >= occ_reg) || (slot_time_reg[i] > in_time_fit);
            match_next[i] = (CNT_W'(i) < occ_reg) && (slot_tag_reg[i] == in_tag);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_cmd.capture) begin
            op_reg    <= in_op;
            time_reg  <= in_time_fit;
            type_reg  <= in_type;
            tag_reg   <= in_tag;
            after_reg <= after_next;
            match_reg <= match_next;
        end
    end

    // Parallel prefix OR marks every entry at or after the first tag match.
    always_comb begin
        pre[0] = match_reg;
        for (int l = 0; l < LVL; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
                end else begin
                    pre[l+1][i] = pre[l][i];
                end
            end
        end
    end

    assign found     = |match_reg;
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign do_insert = (op_reg == OP_INSERT) && !full;
    assign do_remove = (op_reg == OP_REMOVE) && found;

    // Status of the committed request.
    always_comb begin
        case (op_reg)
            OP_INSERT: status_next = full ? STAT_FULL : STAT_OK;
            OP_REMOVE: status_next = found ? STAT_OK : STAT_MISS;
            default:   status_next = (occ_reg == '0) ? STAT_MISS : STAT_OK;
        endcase
    end

    // Next contents of each entry: shift towards the tail on insert, towards
    // the head on remove, otherwise hold.
    always_comb begin
        occ_next = occ_reg;
        if (do_insert) begin
            occ_next = occ_reg + CNT_W'(1);
        end else if (do_remove) begin
            occ_next = occ_reg - CNT_W'(1);
        end
        for (int i = 0; i < DEPTH; i++) begin
            slot_time_next[i] = slot_time_reg[i];
            slot_type_next[i] = slot_type_reg[i];
            slot_tag_next[i]  = slot_tag_reg[i];
            if (do_insert && after_reg[i]) begin
                if (i == 0 || !after_reg[i-1]) begin
                    slot_time_next[i] = time_reg;
                    slot_type_next[i] = type_reg;
                    slot_tag_next[i]  = tag_reg;
                end else begin
                    slot_time_next[i] = slot_time_reg[i-1];
                    slot_type_next[i] = slot_type_reg[i-1];
                    slot_tag_next[i]  = slot_tag_reg[i-1];
                end
            end else if (do_remove && pre[LVL][i] && (i < DEPTH - 1)) begin
                slot_time_next[i] = slot_time_reg[i+1];
                slot_type_next[i] = slot_type_reg[i+1];
                slot_tag_next[i]  = slot_tag_reg[i+1];
            end
        end
    end

    // Store update.
    always_ff @(posedge aclk) begin
        if (ctl_cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                slot_time_reg[i] <= slot_time_next[i];
                slot_type_reg[i] <= slot_type_next[i];
                slot_tag_reg[i]  <= slot_tag_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else if (ctl_cmd.commit) begin
            occ_reg <= occ_next;
        end
    end

    // The result reports the head and count as they stand after the request.
    assign head_time_ext = {{TIME_W{1'b0}}, slot_time_next[0]};
    assign count_ext     = {{COUNT_W{1'b0}}, occ_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl_cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_cmd.commit) begin
            out_status_reg <= status_next;
            out_count_reg  <= count_ext[COUNT_W-1:0];
            out_empty_reg  <= (occ_next == '0);
            if (occ_next == '0) begin
                out_time_reg <= '0;
                out_type_reg <= '0;
                out_tag_reg  <= '0;
            end else begin
                out_time_reg <= head_time_ext[TIME_W-1:0];
                out_type_reg <= slot_type_next[0];
                out_tag_reg  <= slot_tag_next[0];
            end
        end
    end

    assign dp_stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_time         = out_time_reg;
    assign out_type         = out_type_reg;
    assign out_tag          = out_tag_reg;
    assign out_count        = out_count_reg;
    assign out_empty        = out_empty_reg;

endmodule

FILE: rtl/time_ordered_event_queue_unit.sv
`timescale 1ns / 1ps

// Time-ordered event queue: a sorted store of up to DEPTH events kept in
// ascending order of time, with equal times leaving in arrival order.
// The slave channel takes one request per handshake: s_tuser selects insert,
// remove by tag or peek, s_tdata carries the time, type and tag. The master
// channel returns one result per request with a status in m_tuser and the
// head, count and empty flag after the request in m_tdata.
// In the cycle of acceptance every entry compares itself with the request;
// then, once the result register is free, the entries from the insertion or
// removal point shift by one place at once and the result register is loaded.
// A new request is not taken until the last one has been committed.
// The block accepts a new request while a result still waits, but does not
// commit it until the waiting result has been taken, so a stalled receiver
// holds the block after at most one further request.
// Reset empties the queue at once; no clearing pass is needed, as entries
// beyond the count are never reported.

module time_ordered_event_queue_unit
    import toeq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // event_time[31:0], event_type[39:32], event_tag[47:40]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // head_time[31:0], head_type[39:32], head_tag[47:40],
                                   // event_count[52:48], is_empty[53], zero[55:54]
    output logic [1:0]  m_tuser    // status[1:0]
);

    ctl_cmd_t            ctl_cmd;
    dp_stat_t            dp_stat;
    logic [STATUS_W-1:0] out_status;
    logic [TIME_W-1:0]   out_time;
    logic [TYPE_W-1:0]   out_type;
    logic [TAG_W-1:0]    out_tag;
    logic [COUNT_W-1:0]  out_count;
    logic                out_empty;

    toeq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .dp_stat   (dp_stat),
        .ctl_cmd   (ctl_cmd)
    );

    toeq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl_cmd    (ctl_cmd),
        .dp_stat    (dp_stat),
        .in_op      (s_tuser),
        .in_time    (s_tdata[31:0]),
        .in_type    (s_tdata[39:32]),
        .in_tag     (s_tdata[47:40]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_time   (out_time),
        .out_type   (out_type),
        .out_tag    (out_tag),
        .out_count  (out_count),
        .out_empty  (out_empty)
    );

    // Result packing.
    assign m_tdata = {2'b00, out_empty, out_count, out_tag, out_type, out_time};
    assign m_tuser = out_status;

endmodule

FILE: rtl/toeq_checker.sv
`timescale 1ns / 1ps

module toeq_checker
    import toeq_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Requests are processed one at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted in back-to-back cycles");

    // An empty queue reports a cleared head.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[53] |-> (m_tdata[47:0] == 48'd0) && (m_tdata[52:48] == 5'd0))
        else $error("empty queue reports a head event");

    // A refused insert means the queue is occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_FULL) |-> !m_tdata[53])
        else $error("full status on an empty queue");

endmodule

bind time_ordered_event_queue_unit toeq_checker u_toeq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import toeq_pkg::*;

    localparam int STORE_DEPTH  = DEPTH_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int TAG_POOL     = 15;
    localparam int SETTLE_WAIT  = 20;

    // The spare operation code behaves as a peek.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Request mixes of the random part.
    localparam int MIX_FILL    = 0;
    localparam int MIX_DRAIN   = 1;
    localparam int MIX_BALANCE = 2;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TIME_W-1:0]   head_time;
        logic [TYPE_W-1:0]   head_type;
        logic [TAG_W-1:0]    head_tag;
        logic [COUNT_W-1:0]  event_count;
        logic                is_empty;
    } queue_result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] ev_time;
        logic [TYPE_W-1:0] ev_type;
        logic [TAG_W-1:0]  ev_tag;
        bit                typed;
        queue_result_t     want;
    } request_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // event_time[31:0], event_type[39:32], event_tag[47:40]
    logic [1:0]  s_tuser  = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // head_time[31:0], head_type[39:32], head_tag[47:40],
                                  // event_count[52:48], is_empty[53], zero[55:54]
    logic [1:0]  m_tuser;         // status[1:0]

    // Shadow copy of the sorted store.
    logic [TIME_W-1:0] shadow_time [STORE_DEPTH];
    logic [TYPE_W-1:0] shadow_type [STORE_DEPTH];
    logic [TAG_W-1:0]  shadow_tag  [STORE_DEPTH];
    int                shadow_count = 0;

    queue_result_t pending_results[$];
    request_row_t  directed_rows[$];

    bit idle_on = 1'b1;
    int error_count = 0;
    int stall_cycles = 0;
    int n_insert = 0, n_remove = 0, n_peek = 0, n_full = 0, n_miss = 0, peak_count = 0;

    time_ordered_event_queue_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic queue_result_t make_result(input logic [STATUS_W-1:0] st,
                                                  input logic [TIME_W-1:0] t,
                                                  input logic [TYPE_W-1:0] ty,
                                                  input logic [TAG_W-1:0] tg,
                                                  input logic [COUNT_W-1:0] cnt,
                                                  input logic empty);
        queue_result_t r;
        r.status      = st;
        r.head_time   = t;
        r.head_type   = ty;
        r.head_tag    = tg;
        r.event_count = cnt;
        r.is_empty    = empty;
        return r;
    endfunction

    // Apply one request to the shadow store and work out the result it gives.
    function automatic queue_result_t step_event_store(input logic [OP_W-1:0] op,
                                                       input logic [TIME_W-1:0] t,
                                                       input logic [TYPE_W-1:0] ty,
                                                       input logic [TAG_W-1:0] tg);
        int pos;
        int i;
        logic [STATUS_W-1:0] st;
        queue_result_t r;
        st = STAT_OK;
        if (op == OP_INSERT) begin
            if (shadow_count >= STORE_DEPTH) begin
                st = STAT_FULL;
            end else begin
                // The new event goes after every entry with a time not above its own.
                pos = shadow_count;
                for (i = 0; i < shadow_count; i++) begin
                    if (shadow_time[i] > t) begin
                        pos = i;
                        break;
                    end
                end
                for (i = shadow_count; i > pos; i--) begin
                    shadow_time[i] = shadow_time[i-1];
                    shadow_type[i] = shadow_type[i-1];
                    shadow_tag[i]  = shadow_tag[i-1];
                end
                shadow_time[pos] = t;
                shadow_type[pos] = ty;
                shadow_tag[pos]  = tg;
                shadow_count++;
            end
        end else if (op == OP_REMOVE) begin
            // Only the first entry in queue order with the tag is taken out.
            pos = -1;
            for (i = 0; i < shadow_count; i++) begin
                if (shadow_tag[i] == tg) begin
                    pos = i;
                    break;
                end
            end
            if (pos < 0) begin
                st = STAT_MISS;
            end else begin
                for (i = pos; i + 1 < shadow_count; i++) begin
                    shadow_time[i] = shadow_time[i+1];
                    shadow_type[i] = shadow_type[i+1];
                    shadow_tag[i]  = shadow_tag[i+1];
                end
                shadow_count--;
            end
        end else begin
            st = (shadow_count == 0) ? STAT_MISS : STAT_OK;
        end
        if (shadow_count > 0) begin
            r = make_result(st, shadow_time[0], shadow_type[0], shadow_tag[0],
                            COUNT_W'(shadow_count), 1'b0);
        end else begin
            r = make_result(st, '0, '0, '0, '0, 1'b1);
        end
        return r;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                           input logic [TYPE_W-1:0] ty, input logic [TAG_W-1:0] tg,
                           input bit typed, input queue_result_t want);
        request_row_t row;
        row.op      = op;
        row.ev_time = t;
        row.ev_type = ty;
        row.ev_tag  = tg;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endtask

    // Offer one request after a random gap and record its expected result on acceptance.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                                input logic [TYPE_W-1:0] ty, input logic [TAG_W-1:0] tg,
                                input bit typed, input queue_result_t want);
        queue_result_t predicted;
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tg, ty, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = step_event_store(op, t, ty, tg);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            pending_results.push_back(predicted);
        end
        if (op == OP_INSERT) n_insert++;
        else if (op == OP_REMOVE) n_remove++;
        else n_peek++;
        if (predicted.status == STAT_FULL) n_full++;
        if (predicted.status == STAT_MISS) n_miss++;
        if (shadow_count > peak_count) peak_count = shadow_count;
    endtask

    // Hold the sender off until every outstanding result has arrived.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        error_count++;
        if (error_count <= 10) begin
            $display("Mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    // The receiver stalls at random, driven at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(idle_on && $urandom_range(99) < 36);
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unrequested result", '0, m_tdata[31:0]);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser != want.status)
                    note_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[31:0] != want.head_time)
                    note_mismatch("head_time", want.head_time, m_tdata[31:0]);
                if (m_tdata[39:32] != want.head_type)
                    note_mismatch("head_type", 32'(want.head_type), 32'(m_tdata[39:32]));
                if (m_tdata[47:40] != want.head_tag)
                    note_mismatch("head_tag", 32'(want.head_tag), 32'(m_tdata[47:40]));
                if (m_tdata[52:48] != want.event_count)
                    note_mismatch("event_count", 32'(want.event_count),
                                  32'(m_tdata[52:48]));
                if (m_tdata[53] != want.is_empty)
                    note_mismatch("is_empty", 32'(want.is_empty), 32'(m_tdata[53]));
                if (m_tdata[55:54] != 2'b00)
                    note_mismatch("padding", '0, 32'(m_tdata[55:54]));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request or a result.
    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("time_ordered_event_queue_unit verification failed");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    initial begin
        queue_result_t none;
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] t;
        logic [TYPE_W-1:0] ty;
        logic [TAG_W-1:0]  tg;
        int mix;
        int pick;
        int insert_share;

        none = make_result('0, '0, '0, '0, '0, 1'b0);

        // Directed table: empty queue, extremes of every field, equal times, full store.
        add_row(OP_PEEK,   '0, '0, '0, 1'b1, make_result(STAT_MISS, '0, '0, '0, 5'd0, 1'b1));
        add_row(OP_REMOVE, '0, '0, 8'h05, 1'b1,
                make_result(STAT_MISS, '0, '0, '0, 5'd0, 1'b1));
        add_row(OP_SPARE,  '0, '0, '0, 1'b1, make_result(STAT_MISS, '0, '0, '0, 5'd0, 1'b1));
        add_row(OP_INSERT, '1, '1, '1, 1'b1, make_result(STAT_OK, '1, '1, '1, 5'd1, 1'b0));
        add_row(OP_INSERT, '0, '0, '0, 1'b1, make_result(STAT_OK, '0, '0, '0, 5'd2, 1'b0));
        add_row(OP_REMOVE, '0, '0, 8'h77, 1'b1,
                make_result(STAT_MISS, '0, '0, '0, 5'd2, 1'b0));
        add_row(OP_INSERT, '0, 8'h01, 8'h01, 1'b0, none);
        add_row(OP_REMOVE, '0, '0, 8'h00, 1'b0, none);
        add_row(OP_PEEK,   '0, '0, '0, 1'b0, none);
        for (int k = 0; k < 14; k++) begin
            add_row(OP_INSERT, 32'((k % 4) * 32'h0001_8000), 8'(8'h80 ^ k), 8'(8'h20 + k % 7),
                    1'b0, none);
        end
        add_row(OP_INSERT, 32'h0000_4000, 8'h55, 8'hAA, 1'b0, none);
        add_row(OP_SPARE,  '0, '0, '0, 1'b0, none);

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].ev_time,
                         directed_rows[i].ev_type, directed_rows[i].ev_tag,
                         directed_rows[i].typed, directed_rows[i].want);
        end

        // Random part: phases that favour filling, draining or neither, so the
        // store swings between full and empty with many tag hits on removal.
        mix = MIX_BALANCE;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) mix = $urandom_range(MIX_FILL, MIX_BALANCE);
            idle_on = !(n >= 450 && n < 650);
            if (n > 0 && n % 275 == 0) drain_results();

            insert_share = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 38 : 55;
            pick = $urandom_range(99);
            if (pick < 3) op = OP_SPARE;
            else if (pick < 13) op = OP_PEEK;
            else if (pick < insert_share) op = OP_INSERT;
            else op = OP_REMOVE;

            case ($urandom_range(0, 4))
                0, 1: t = $urandom;
                2, 3: t = TIME_W'($urandom_range(0, 7)) << 16;
                default: t = $urandom_range(0, 1) ? '1 : '0;
            endcase
            ty = TYPE_W'($urandom);
            tg = ($urandom_range(0, 3) == 0) ? TAG_W'($urandom)
                                             : TAG_W'($urandom_range(0, TAG_POOL));
            if (op == OP_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0) begin
                tg = shadow_tag[$urandom_range(0, shadow_count - 1)];
            end
            send_request(op, t, ty, tg, 1'b0, none);
        end

        idle_on = 1'b1;
        drain_results();
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (pending_results.size() != 0) begin
            note_mismatch("results never delivered", '0, pending_results.size());
        end

        $display("Run covered %0d inserts (%0d refused on a full store), %0d removes, %0d peeks.",
                 n_insert, n_full, n_remove, n_peek);
        $display("%0d requests met an empty queue or a missing tag; peak occupancy %0d.",
                 n_miss, peak_count);
        if (error_count == 0) begin
            $display("time_ordered_event_queue_unit verification clean");
        end else begin
            $display("time_ordered_event_queue_unit verification failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/toeq_pkg.sv
rtl/toeq_ctrl.sv
rtl/toeq_datapath.sv
rtl/time_ordered_event_queue_unit.sv
rtl/toeq_checker.sv
tb/sv/testbench.sv
